### design/rgf_pkg.sv
// Shared constants, command and status types and channel helpers of the rectangle fill engine.
`default_nettype none
package rgf_pkg;

	localparam int COORD_BITS    = 13;
	localparam int FRAC_BITS     = 16;
	localparam int CHAN_BITS     = 8;
	localparam int NUM_CHAN      = 3;
	localparam int COLOR_BITS    = NUM_CHAN * CHAN_BITS;
	localparam int ADDR_BITS     = 33;
	localparam int BASE_BITS     = 32;
	localparam int STRIDE_BITS   = 14;
	localparam int BPP_BITS      = 3;
	localparam int POS_BITS      = COORD_BITS + 1;
	localparam int PROD_BITS     = POS_BITS + STRIDE_BITS;
	localparam int DIV_BITS      = CHAN_BITS + FRAC_BITS;
	localparam int STEP_BITS     = DIV_BITS + 1;
	localparam int ACC_BITS      = DIV_BITS + 2;
	localparam int DCNT_BITS     = $clog2(DIV_BITS + 1);
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_BASE   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BPP    = 2'd2;

	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 14'd640;
	localparam logic [BPP_BITS-1:0]    BPP_RESET    = 3'd4;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	typedef struct packed {
		logic load;
		logic advance;
		logic div_step;
		logic div_finish;
		logic mul;
		logic out_load;
	} rgf_cmd_t;

	typedef struct packed {
		logic busy;
	} rgf_stat_t;

	function automatic logic [CHAN_BITS-1:0] chan_of(input logic [COLOR_BITS-1:0] color,
			input int unsigned idx);
		return color[(NUM_CHAN - 1 - idx) * CHAN_BITS +: CHAN_BITS];
	endfunction

	// Truncate the accumulator to its integer part and clamp to the channel range.
	function automatic logic [CHAN_BITS-1:0] clamp_chan(input logic signed [ACC_BITS-1:0] acc);
		logic [CHAN_BITS-1:0] res;
		if (acc[ACC_BITS-1]) begin
			res = '0;
		end else if (|acc[ACC_BITS-2:FRAC_BITS+CHAN_BITS]) begin
			res = '1;
		end else begin
			res = acc[FRAC_BITS+CHAN_BITS-1:FRAC_BITS];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### design/rgf_if.sv
// Channel interfaces of the rectangle fill engine: fill requests, pixel writes, register writes.
`default_nettype none
interface rgf_req_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic                           gradient_mode;
	logic [rgf_pkg::COORD_BITS-1:0] origin_x;
	logic [rgf_pkg::COORD_BITS-1:0] origin_y;
	logic [rgf_pkg::COORD_BITS-1:0] rect_width;
	logic [rgf_pkg::COORD_BITS-1:0] rect_height;
	logic [rgf_pkg::COLOR_BITS-1:0] from_color;
	logic [rgf_pkg::COLOR_BITS-1:0] to_color;

	modport source (output valid, action, gradient_mode, origin_x, origin_y, rect_width,
		rect_height, from_color, to_color, input ready);
	modport sink (input valid, action, gradient_mode, origin_x, origin_y, rect_width,
		rect_height, from_color, to_color, output ready);
endinterface

interface rgf_pix_if;
	logic                          valid;
	logic                          ready;
	logic [rgf_pkg::ADDR_BITS-1:0] pixel_address;
	logic [rgf_pkg::CHAN_BITS-1:0] red;
	logic [rgf_pkg::CHAN_BITS-1:0] green;
	logic [rgf_pkg::CHAN_BITS-1:0] blue;
	logic                          last_pixel;

	modport source (output valid, pixel_address, red, green, blue, last_pixel, input ready);
	modport sink (input valid, pixel_address, red, green, blue, last_pixel, output ready);
endinterface

interface rgf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rgf_pkg::CFG_IDX_BITS-1:0]  index;
	logic [rgf_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/rgf_ctrl.sv
// Controller of the rectangle fill engine: sequences start, division, address and output steps.
`default_nettype none
module rgf_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	input  wire logic                           req_action,
	input  wire logic                           req_gradient,
	input  wire logic [rgf_pkg::COORD_BITS-1:0] req_width,
	output logic                                req_ready,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	input  wire rgf_pkg::rgf_stat_t             stat,
	output rgf_pkg::rgf_cmd_t                   cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_MUL  = 2'd2;
	localparam logic [1:0] S_ADDR = 2'd3;

	logic [1:0]                    state_q;
	logic [1:0]                    state_d;
	logic [rgf_pkg::DCNT_BITS-1:0] div_cnt_q;
	logic                          out_valid_q;
	logic                          accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_action == rgf_pkg::ACT_START) begin
						cmd.load = 1'b1;
						if (req_gradient && (req_width != '0)) begin
							state_d = S_DIV;
						end
					end else if (stat.busy) begin
						cmd.advance = 1'b1;
						state_d     = S_MUL;
					end
				end
			end
			S_DIV: begin
				if (div_cnt_q == rgf_pkg::DCNT_BITS'(rgf_pkg::DIV_BITS)) begin
					cmd.div_finish = 1'b1;
					state_d        = S_IDLE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADDR;
			end
			S_ADDR: begin
				// hold the finished pixel until the output register frees up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (div_cnt_q == rgf_pkg::DCNT_BITS'(rgf_pkg::DIV_BITS))
		|=> (state_q == S_IDLE))
		else $error("division did not finish after its last step");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while its item waits");

	a_adv_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_action == rgf_pkg::ACT_ADVANCE) && stat.busy
		|=> (state_q == S_MUL) ##1 (state_q == S_ADDR))
		else $error("advance item did not enter the address sequence");

endmodule
`default_nettype wire

### design/rgf_datapath.sv
// Datapath of the rectangle fill engine: registers, fill state, step dividers, address and colors.
`default_nettype none
module rgf_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rgf_pkg::rgf_cmd_t                 cmd,
	output rgf_pkg::rgf_stat_t                     stat,
	input  wire logic                              cfg_we,
	input  wire logic [rgf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [rgf_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                              req_gradient,
	input  wire logic [rgf_pkg::COORD_BITS-1:0]    req_origin_x,
	input  wire logic [rgf_pkg::COORD_BITS-1:0]    req_origin_y,
	input  wire logic [rgf_pkg::COORD_BITS-1:0]    req_width,
	input  wire logic [rgf_pkg::COORD_BITS-1:0]    req_height,
	input  wire logic [rgf_pkg::COLOR_BITS-1:0]    req_from,
	input  wire logic [rgf_pkg::COLOR_BITS-1:0]    req_to,
	output logic [rgf_pkg::ADDR_BITS-1:0]          out_address,
	output logic [rgf_pkg::CHAN_BITS-1:0]          out_red,
	output logic [rgf_pkg::CHAN_BITS-1:0]          out_green,
	output logic [rgf_pkg::CHAN_BITS-1:0]          out_blue,
	output logic                                   out_last
);

	localparam int CB = rgf_pkg::COORD_BITS;
	localparam int NC = rgf_pkg::NUM_CHAN;

	// configuration registers
	logic [rgf_pkg::BASE_BITS-1:0]   base_q;
	logic [rgf_pkg::STRIDE_BITS-1:0] stride_q;
	logic [rgf_pkg::BPP_BITS-1:0]    bpp_q;

	// fill state
	logic                            busy_q;
	logic                            grad_q;
	logic [CB-1:0]                   left_q;
	logic [CB-1:0]                   top_q;
	logic [CB-1:0]                   span_w_q;
	logic [CB-1:0]                   span_h_q;
	logic [CB-1:0]                   col_q;
	logic [CB-1:0]                   row_q;
	logic [rgf_pkg::COLOR_BITS-1:0]  solid_q;
	logic signed [rgf_pkg::ACC_BITS-1:0]  acc_q  [NC];
	logic signed [rgf_pkg::STEP_BITS-1:0] step_q [NC];

	// step dividers, one lane per channel
	logic [rgf_pkg::DIV_BITS-1:0] num_q [NC];
	logic [rgf_pkg::DIV_BITS-1:0] quo_q [NC];
	logic [CB-1:0]                rem_q [NC];
	logic                         neg_q [NC];

	// pixel in flight
	logic [rgf_pkg::POS_BITS-1:0]  x_q;
	logic [rgf_pkg::POS_BITS-1:0]  y_q;
	logic [rgf_pkg::PROD_BITS-1:0] prod_q;
	logic [rgf_pkg::CHAN_BITS-1:0] rgb_q [NC];
	logic                          last_q;

	// output register
	logic [rgf_pkg::ADDR_BITS-1:0] addr_out_q;
	logic [rgf_pkg::CHAN_BITS-1:0] red_out_q;
	logic [rgf_pkg::CHAN_BITS-1:0] green_out_q;
	logic [rgf_pkg::CHAN_BITS-1:0] blue_out_q;
	logic                          last_out_q;

	logic signed [rgf_pkg::ACC_BITS-1:0]  acc_nx  [NC];
	logic [rgf_pkg::CHAN_BITS-1:0]        rgb_nx  [NC];
	logic [rgf_pkg::CHAN_BITS-1:0]        from_ch [NC];
	logic signed [rgf_pkg::CHAN_BITS:0]   diff    [NC];
	logic [rgf_pkg::CHAN_BITS-1:0]        diff_mag [NC];
	logic [CB:0]                          rem_sh  [NC];
	logic                                 rem_ge  [NC];
	logic [rgf_pkg::STEP_BITS-1:0]        quo_ext [NC];
	logic [CB:0]                          row_inc;
	logic [CB:0]                          col_inc;
	logic [CB-1:0]                        col_nx;
	logic [CB-1:0]                        row_nx;
	logic                                 last_nx;
	logic [rgf_pkg::ADDR_BITS-1:0]        lin_addr;
	logic [rgf_pkg::ADDR_BITS-1:0]        pix_addr;

	assign stat.busy = busy_q;

	always_comb begin
		for (int k = 0; k < NC; k++) begin
			from_ch[k] = rgf_pkg::chan_of(req_from, k);
			diff[k]    = $signed({1'b0, from_ch[k]}) - $signed({1'b0, rgf_pkg::chan_of(req_to, k)});
			diff_mag[k] = diff[k][rgf_pkg::CHAN_BITS] ? rgf_pkg::CHAN_BITS'(-diff[k])
				: diff[k][rgf_pkg::CHAN_BITS-1:0];
			rem_sh[k]  = {rem_q[k], num_q[k][rgf_pkg::DIV_BITS-1]};
			rem_ge[k]  = (rem_sh[k] >= {1'b0, span_w_q});
			quo_ext[k] = {1'b0, quo_q[k]};
			// first pixel of each column steps the gradient
			if (grad_q && (row_q == '0)) begin
				acc_nx[k] = acc_q[k] - rgf_pkg::ACC_BITS'(step_q[k]);
			end else begin
				acc_nx[k] = acc_q[k];
			end
			if (grad_q) begin
				rgb_nx[k] = rgf_pkg::clamp_chan(acc_nx[k]);
			end else begin
				rgb_nx[k] = rgf_pkg::chan_of(solid_q, k);
			end
		end
	end

	// walk order: gradient is column-major, solid is row-major
	always_comb begin
		row_inc = {1'b0, row_q} + 1'b1;
		col_inc = {1'b0, col_q} + 1'b1;
		if (grad_q) begin
			if (row_inc >= {1'b0, span_h_q}) begin
				row_nx = '0;
				col_nx = col_inc[CB-1:0];
				last_nx = (col_inc >= {1'b0, span_w_q});
			end else begin
				row_nx = row_inc[CB-1:0];
				col_nx = col_q;
				last_nx = ({1'b0, col_q} >= {1'b0, span_w_q});
			end
		end else begin
			if (col_inc >= {1'b0, span_w_q}) begin
				col_nx = '0;
				row_nx = row_inc[CB-1:0];
				last_nx = (row_inc >= {1'b0, span_h_q});
			end else begin
				col_nx = col_inc[CB-1:0];
				row_nx = row_q;
				last_nx = ({1'b0, row_q} >= {1'b0, span_h_q});
			end
		end
	end

	assign lin_addr = rgf_pkg::ADDR_BITS'(x_q) + rgf_pkg::ADDR_BITS'(prod_q);
	assign pix_addr = rgf_pkg::ADDR_BITS'(base_q)
		+ lin_addr * rgf_pkg::ADDR_BITS'(bpp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			stride_q <= rgf_pkg::STRIDE_RESET;
			bpp_q    <= rgf_pkg::BPP_RESET;
			busy_q   <= 1'b0;
			grad_q   <= 1'b0;
			left_q   <= '0;
			top_q    <= '0;
			span_w_q <= '0;
			span_h_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			solid_q  <= '0;
			for (int k = 0; k < NC; k++) begin
				acc_q[k]  <= '0;
				step_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rgf_pkg::REG_BASE:   base_q   <= cfg_data[rgf_pkg::BASE_BITS-1:0];
					rgf_pkg::REG_STRIDE: stride_q <= cfg_data[rgf_pkg::STRIDE_BITS-1:0];
					rgf_pkg::REG_BPP:    bpp_q    <= cfg_data[rgf_pkg::BPP_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				busy_q   <= (req_width != '0) && (req_height != '0);
				grad_q   <= req_gradient;
				left_q   <= req_origin_x;
				top_q    <= req_origin_y;
				span_w_q <= req_width;
				span_h_q <= req_height;
				col_q    <= '0;
				row_q    <= '0;
				solid_q  <= req_from;
				for (int k = 0; k < NC; k++) begin
					acc_q[k]  <= rgf_pkg::ACC_BITS'({from_ch[k], {rgf_pkg::FRAC_BITS{1'b0}}});
					step_q[k] <= '0;
				end
			end else if (cmd.advance) begin
				col_q <= col_nx;
				row_q <= row_nx;
				if (last_nx) begin
					busy_q <= 1'b0;
				end
				for (int k = 0; k < NC; k++) begin
					acc_q[k] <= acc_nx[k];
				end
			end else if (cmd.div_finish) begin
				for (int k = 0; k < NC; k++) begin
					step_q[k] <= neg_q[k] ? -$signed(quo_ext[k]) : $signed(quo_ext[k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < NC; k++) begin
				num_q[k] <= {diff_mag[k], {rgf_pkg::FRAC_BITS{1'b0}}};
				neg_q[k] <= diff[k][rgf_pkg::CHAN_BITS];
				quo_q[k] <= '0;
				rem_q[k] <= '0;
			end
		end else if (cmd.div_step) begin
			// one restoring quotient bit per cycle in each lane
			for (int k = 0; k < NC; k++) begin
				num_q[k] <= {num_q[k][rgf_pkg::DIV_BITS-2:0], 1'b0};
				quo_q[k] <= {quo_q[k][rgf_pkg::DIV_BITS-2:0], rem_ge[k]};
				if (rem_ge[k]) begin
					rem_q[k] <= CB'(rem_sh[k] - {1'b0, span_w_q});
				end else begin
					rem_q[k] <= rem_sh[k][CB-1:0];
				end
			end
		end
		if (cmd.advance) begin
			x_q    <= {1'b0, left_q} + {1'b0, col_q};
			y_q    <= {1'b0, top_q} + {1'b0, row_q};
			last_q <= last_nx;
			for (int k = 0; k < NC; k++) begin
				rgb_q[k] <= rgb_nx[k];
			end
		end
		if (cmd.mul) begin
			prod_q <= y_q * stride_q;
		end
		if (cmd.out_load) begin
			addr_out_q  <= pix_addr;
			red_out_q   <= rgb_q[0];
			green_out_q <= rgb_q[1];
			blue_out_q  <= rgb_q[2];
			last_out_q  <= last_q;
		end
	end

	assign out_address = addr_out_q;
	assign out_red     = red_out_q;
	assign out_green   = green_out_q;
	assign out_blue    = blue_out_q;
	assign out_last    = last_out_q;

	a_busy_size: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ((span_w_q != '0) && (span_h_q != '0)))
		else $error("fill busy with an empty rectangle");

endmodule
`default_nettype wire

### design/rect_gradient_fill.sv
// Top level of the rectangle fill engine with solid and horizontal gradient modes.
// A start item (action 0) loads origin, size, mode and colors; a gradient
// start with nonzero width then keeps the engine busy while three
// bit-serial dividers, one per channel, form the per-column color steps one quotient bit
// per cycle. Each advance item (action 1) while a fill is active produces one pixel
// write and passes through capture of coordinates and colors, the row
// times stride multiply, and the final address multiply-add into the output register.
// The output register lets the next item be accepted while a pixel waits to be taken.
// An advance with no active fill is taken and produces nothing, and a
// start during a fill aborts it. Register writes are taken at any time (ready is
// held high) and must land only while the engine is idle; unknown indexes are ignored.
`default_nettype none
module rect_gradient_fill (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rgf_cfg_if.sink    cfg,
	rgf_req_if.sink    req,
	rgf_pix_if.source  pix
);

	rgf_pkg::rgf_cmd_t  cmd;
	rgf_pkg::rgf_stat_t stat;

	assign cfg.ready = 1'b1;

	rgf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req.valid),
		.req_action   (req.action),
		.req_gradient (req.gradient_mode),
		.req_width    (req.rect_width),
		.req_ready    (req.ready),
		.out_ready    (pix.ready),
		.out_valid    (pix.valid),
		.stat         (stat),
		.cmd          (cmd)
	);

	rgf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.req_gradient (req.gradient_mode),
		.req_origin_x (req.origin_x),
		.req_origin_y (req.origin_y),
		.req_width    (req.rect_width),
		.req_height   (req.rect_height),
		.req_from     (req.from_color),
		.req_to       (req.to_color),
		.out_address  (pix.pixel_address),
		.out_red      (pix.red),
		.out_green    (pix.green),
		.out_blue     (pix.blue),
		.out_last     (pix.last_pixel)
	);

endmodule
`default_nettype wire

### verif/tb_rect_gradient_fill.sv
// Self-checking testbench of the rectangle fill engine: directed table, random fills, pixel checks.
module tb_rect_gradient_fill;
	import rgf_pkg::*;

	typedef struct packed {
		logic                  action;
		logic                  gradient_mode;
		logic [COORD_BITS-1:0] origin_x;
		logic [COORD_BITS-1:0] origin_y;
		logic [COORD_BITS-1:0] rect_width;
		logic [COORD_BITS-1:0] rect_height;
		logic [COLOR_BITS-1:0] from_color;
		logic [COLOR_BITS-1:0] to_color;
	} fill_item_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] pixel_address;
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
		logic                 last_pixel;
	} pixel_t;

	typedef struct {
		fill_item_t item;
		bit         typed;
		pixel_t     pix;
	} dir_row_t;

	localparam int              SETTLE_CYCLES = 40;
	localparam int              PHASE_ITEMS   = 82;
	localparam longint unsigned ADDR_MASK     = (64'd1 << ADDR_BITS) - 64'd1;

	logic clk;
	logic arst_n;

	rgf_req_if req();
	rgf_pix_if pix();
	rgf_cfg_if cfg();

	rect_gradient_fill DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.pix    (pix)
	);

	// framebuffer registers as last written
	logic [BASE_BITS-1:0]   fb_base   = '0;
	logic [STRIDE_BITS-1:0] fb_stride = STRIDE_RESET;
	logic [BPP_BITS-1:0]    fb_bpp    = BPP_RESET;

	// fill engine state
	bit                    fill_busy  = 0;
	bit                    fill_grad  = 0;
	int unsigned           fill_left  = 0;
	int unsigned           fill_top   = 0;
	int unsigned           fill_w     = 0;
	int unsigned           fill_h     = 0;
	int unsigned           fill_col   = 0;
	int unsigned           fill_row   = 0;
	logic [COLOR_BITS-1:0] fill_color = '0;
	longint                fill_acc[NUM_CHAN];
	longint                fill_step[NUM_CHAN];

	pixel_t   pixel_q[$];
	dir_row_t dir_rows[$];

	int err_count   = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold     = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("FAIL rect_gradient_fill");
		$finish;
	end

	function automatic logic [CHAN_BITS-1:0] acc_to_chan(input longint acc);
		if (acc < 0) begin
			return '0;
		end
		if ((acc >>> FRAC_BITS) > 255) begin
			return 8'hFF;
		end
		return CHAN_BITS'(acc >>> FRAC_BITS);
	endfunction

	// Apply one accepted item to the engine state; return 1 when it writes a pixel.
	function automatic bit predict_pixel(input fill_item_t it, output pixel_t p);
		longint          f;
		longint          t;
		longint unsigned x;
		longint unsigned y;
		longint unsigned lin;
		p = '0;
		if (it.action == ACT_START) begin
			fill_grad  = it.gradient_mode;
			fill_left  = it.origin_x;
			fill_top   = it.origin_y;
			fill_w     = it.rect_width;
			fill_h     = it.rect_height;
			fill_color = it.from_color;
			fill_col   = 0;
			fill_row   = 0;
			for (int k = 0; k < NUM_CHAN; k++) begin
				f = longint'((it.from_color >> (CHAN_BITS * (NUM_CHAN - 1 - k))) & 24'hFF);
				t = longint'((it.to_color >> (CHAN_BITS * (NUM_CHAN - 1 - k))) & 24'hFF);
				fill_acc[k] = f * (longint'(1) << FRAC_BITS);
				if (fill_grad && fill_w != 0) begin
					fill_step[k] = ((f - t) * (longint'(1) << FRAC_BITS)) / longint'(fill_w);
				end else begin
					fill_step[k] = 0;
				end
			end
			fill_busy = (fill_w != 0) && (fill_h != 0);
			return 0;
		end
		if (!fill_busy) begin
			return 0;
		end
		x = longint'(fill_left + fill_col);
		y = longint'(fill_top + fill_row);
		lin = (x + y * fb_stride) & ADDR_MASK;
		p.pixel_address = ADDR_BITS'((fb_base + lin * fb_bpp) & ADDR_MASK);
		if (fill_grad) begin
			// step once at the top of every column, first column included
			if (fill_row == 0) begin
				for (int k = 0; k < NUM_CHAN; k++) begin
					fill_acc[k] -= fill_step[k];
				end
			end
			p.red   = acc_to_chan(fill_acc[0]);
			p.green = acc_to_chan(fill_acc[1]);
			p.blue  = acc_to_chan(fill_acc[2]);
			fill_row++;
			if (fill_row >= fill_h) begin
				fill_row = 0;
				fill_col++;
			end
			p.last_pixel = fill_col >= fill_w;
		end else begin
			p.red   = fill_color[23:16];
			p.green = fill_color[15:8];
			p.blue  = fill_color[7:0];
			fill_col++;
			if (fill_col >= fill_w) begin
				fill_col = 0;
				fill_row++;
			end
			p.last_pixel = fill_row >= fill_h;
		end
		if (p.last_pixel) begin
			fill_busy = 0;
		end
		return 1;
	endfunction

	function automatic void dir_start(input logic mode, input int ox, input int oy, input int w,
			input int h, input logic [COLOR_BITS-1:0] from, input logic [COLOR_BITS-1:0] to);
		dir_row_t r;
		r.item = '0;
		r.item.action        = ACT_START;
		r.item.gradient_mode = mode;
		r.item.origin_x      = COORD_BITS'(ox);
		r.item.origin_y      = COORD_BITS'(oy);
		r.item.rect_width    = COORD_BITS'(w);
		r.item.rect_height   = COORD_BITS'(h);
		r.item.from_color    = from;
		r.item.to_color      = to;
		r.typed = 0;
		r.pix   = '0;
		dir_rows.push_back(r);
	endfunction

	function automatic void dir_advance(input bit typed, input longint unsigned addr,
			input logic [7:0] r8, input logic [7:0] g8, input logic [7:0] b8, input logic last);
		dir_row_t r;
		r.item = '0;
		r.item.action = ACT_ADVANCE;
		r.typed = typed;
		r.pix.pixel_address = ADDR_BITS'(addr);
		r.pix.red        = r8;
		r.pix.green      = g8;
		r.pix.blue       = b8;
		r.pix.last_pixel = last;
		dir_rows.push_back(r);
	endfunction

	task automatic reg_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(negedge clk);
		while (!cfg.ready) @(negedge clk);
		@(posedge clk);
		case (idx)
			REG_BASE: begin
				fb_base = val;
			end
			REG_STRIDE: begin
				fb_stride = val[STRIDE_BITS-1:0];
			end
			REG_BPP: begin
				fb_bpp = val[BPP_BITS-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_framebuffer(input logic [31:0] base, input int stride, input int bpp);
		reg_write(REG_BASE, base);
		reg_write(REG_STRIDE, CFG_DATA_BITS'(stride));
		reg_write(REG_BPP, CFG_DATA_BITS'(bpp));
		cfg.valid <= 1'b0;
	endtask

	task automatic send_item(input fill_item_t it, output bit produced, output pixel_t p);
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid         <= 1'b1;
		req.action        <= it.action;
		req.gradient_mode <= it.gradient_mode;
		req.origin_x      <= it.origin_x;
		req.origin_y      <= it.origin_y;
		req.rect_width    <= it.rect_width;
		req.rect_height   <= it.rect_height;
		req.from_color    <= it.from_color;
		req.to_color      <= it.to_color;
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
		produced = predict_pixel(it, p);
	endtask

	task automatic pause_until_drained();
		req.valid <= 1'b0;
		do @(posedge clk); while (pixel_q.size() != 0);
	endtask

	task automatic settle();
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic fill_item_t noise_item();
		fill_item_t it;
		it = fill_item_t'({$urandom, $urandom, $urandom, $urandom});
		return it;
	endfunction

	// One start followed by a run of advances: complete, cut short, or empty.
	task automatic random_fill(inout int counted);
		fill_item_t it;
		bit         produced;
		pixel_t     p;
		int         kind;
		int         n_adv;
		it = noise_item();
		it.action = ACT_START;
		kind = $urandom_range(99);
		if (kind < 70) begin
			it.rect_width  = COORD_BITS'($urandom_range(5, 1));
			it.rect_height = COORD_BITS'($urandom_range(5, 1));
			n_adv = it.rect_width * it.rect_height + ($urandom_range(99) < 15 ? 1 : 0);
		end else if (kind < 85) begin
			it.rect_width  = COORD_BITS'($urandom_range(8191));
			it.rect_height = COORD_BITS'($urandom_range(8191));
			n_adv = $urandom_range(6);
		end else begin
			if ($urandom_range(1) == 1) begin
				it.rect_width  = '0;
				it.rect_height = COORD_BITS'($urandom_range(5));
			end else begin
				it.rect_width  = COORD_BITS'($urandom_range(5, 1));
				it.rect_height = '0;
			end
			n_adv = $urandom_range(2);
		end
		send_item(it, produced, p);
		counted++;
		repeat (n_adv) begin
			it = noise_item();
			it.action = ACT_ADVANCE;
			send_item(it, produced, p);
			if (produced) begin
				pixel_q.push_back(p);
				counted++;
			end
		end
	endtask

	// pixel sink: random stalls plus one long hold-off
	initial begin
		pix.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				pix.ready <= 1'b0;
				rx_hold--;
			end else begin
				pix.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(negedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && pix.valid === 1'b1 && pix.ready) begin
			if (pixel_q.size() == 0) begin
				$error("unexpected pixel write at address %h", pix.pixel_address);
				err_count++;
			end else begin
				want = pixel_q.pop_front();
				if (pix.pixel_address !== want.pixel_address) begin
					$error("pixel_address: expected %h, got %h", want.pixel_address,
						pix.pixel_address);
					err_count++;
				end
				if (pix.red !== want.red) begin
					$error("red: expected %h, got %h", want.red, pix.red);
					err_count++;
				end
				if (pix.green !== want.green) begin
					$error("green: expected %h, got %h", want.green, pix.green);
					err_count++;
				end
				if (pix.blue !== want.blue) begin
					$error("blue: expected %h, got %h", want.blue, pix.blue);
					err_count++;
				end
				if (pix.last_pixel !== want.last_pixel) begin
					$error("last_pixel: expected %b, got %b", want.last_pixel, pix.last_pixel);
					err_count++;
				end
			end
		end
	end

	initial begin
		fill_item_t it;
		bit         produced;
		pixel_t     p;
		int         counted;
		bit         mid_pause;
		arst_n            <= 1'b0;
		req.valid         <= 1'b0;
		req.action        <= ACT_START;
		req.gradient_mode <= 1'b0;
		req.origin_x      <= '0;
		req.origin_y      <= '0;
		req.rect_width    <= '0;
		req.rect_height   <= '0;
		req.from_color    <= '0;
		req.to_color      <= '0;
		cfg.valid         <= 1'b0;
		cfg.index         <= REG_BASE;
		cfg.data          <= '0;
		for (int k = 0; k < NUM_CHAN; k++) begin
			fill_acc[k]  = 0;
			fill_step[k] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset register values
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_start(0, 0, 0, 1, 1, 24'hFFFFFF, 24'h000000);
		dir_advance(1, 0, 8'hFF, 8'hFF, 8'hFF, 1);
		dir_start(0, 8191, 8191, 2, 2, 24'h123456, 24'hFFFFFF);
		dir_advance(1, 21001724, 8'h12, 8'h34, 8'h56, 0);
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_start(1, 10, 3, 1, 2, 24'hFF0000, 24'h00FF00);
		dir_advance(1, 7720, 8'h00, 8'hFF, 8'h00, 0);
		dir_advance(1, 10280, 8'h00, 8'hFF, 8'h00, 1);
		dir_start(1, 0, 0, 3, 1, 24'h000000, 24'hFFFFFF);
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_start(1, 0, 0, 8191, 8191, 24'hFFFFFF, 24'h000000);
		dir_advance(0, 0, 0, 0, 0, 0);
		// zero width, then zero height: nothing drawn
		dir_start(0, 5, 5, 0, 5, 24'hABCDEF, 24'h000000);
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_start(1, 5, 5, 3, 0, 24'hABCDEF, 24'h123456);
		dir_advance(0, 0, 0, 0, 0, 0);
		// abort a solid fill with a gradient start
		dir_start(0, 1, 1, 3, 3, 24'h00FF00, 24'h000000);
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_start(1, 2, 2, 2, 1, 24'h808080, 24'h000000);
		dir_advance(0, 0, 0, 0, 0, 0);
		dir_advance(0, 0, 0, 0, 0, 0);

		tx_idle_pct = 26;
		rx_idle_pct = 56;
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].item, produced, p);
			if (produced) begin
				pixel_q.push_back(dir_rows[i].typed ? dir_rows[i].pix : p);
			end
		end
		settle();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_framebuffer(32'h0000_1000, 640, 3);
				1: set_framebuffer(32'hFFFF_FFFF, 8192, 4);
				2: set_framebuffer($urandom, 1, 3);
				3: set_framebuffer(32'h0000_0000, 16383, 7);
				4: set_framebuffer($urandom, 0, 0);
				default: set_framebuffer($urandom, $urandom_range(8192, 1), $urandom_range(4, 3));
			endcase
			tx_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 56 : 0;
			rx_idle_pct = (phase < 2) ? 56 : (phase < 4) ? 26 : 0;
			counted = 0;
			mid_pause = 0;
			if (phase == 1) begin
				// hold the sink off while a full solid fill is offered
				rx_hold = 150;
				it = noise_item();
				it.action        = ACT_START;
				it.gradient_mode = 1'b0;
				it.rect_width    = 8;
				it.rect_height   = 8;
				send_item(it, produced, p);
				counted++;
				repeat (64) begin
					it = noise_item();
					it.action = ACT_ADVANCE;
					send_item(it, produced, p);
					if (produced) begin
						pixel_q.push_back(p);
						counted++;
					end
				end
			end
			while (counted < PHASE_ITEMS) begin
				random_fill(counted);
				if (!mid_pause && counted >= PHASE_ITEMS / 2) begin
					pause_until_drained();
					mid_pause = 1;
				end
			end
			// abort any unfinished fill so the engine is idle for the register writes
			it = '0;
			it.action = ACT_START;
			send_item(it, produced, p);
			settle();
		end

		if (err_count == 0) begin
			$display("PASS rect_gradient_fill");
		end else begin
			$display("FAIL rect_gradient_fill");
		end
		$finish;
	end

endmodule

### sim.f
design/rgf_pkg.sv
design/rgf_if.sv
design/rgf_ctrl.sv
design/rgf_datapath.sv
design/rect_gradient_fill.sv
verif/tb_rect_gradient_fill.sv
